// ===== design/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB to HSL pixel core package
// Shared widths, hue offsets, the divider stage payload and the radix-4
// restoring divide step used by the pixel pipeline.
// ---------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int ChW       = 8;
    localparam int HueW      = 15;
    localparam int SatW      = 16;
    localparam int SumW      = 9;
    localparam int QuoW      = 16;
    localparam int DivStages = QuoW / 2;
    localparam int MulW      = 11;

    // Offsets added to the hue quotient; they already hold the -3840 bias of
    // the green and blue formulas.
    localparam logic [HueW-1:0] HueOffsRed   = 15'd0;
    localparam logic [HueW-1:0] HueOffsGreen = 15'd3840;
    localparam logic [HueW-1:0] HueOffsBlue  = 15'd11520;

    typedef struct packed {
        logic [8:0]        srem;
        logic [QuoW-1:0]   snum;
        logic [8:0]        sden;
        logic [QuoW-1:0]   sq;
        logic [7:0]        hrem;
        logic [QuoW-1:0]   hnum;
        logic [7:0]        hdiv;
        logic [QuoW-1:0]   hq;
        logic [HueW-1:0]   hoffs;
        logic              gray;
        logic [SumW-1:0]   sum;
        logic [ChW-1:0]    alpha;
    } t_div_pl;

    typedef struct packed {
        logic [8:0] rem;
        logic [1:0] q;
    } t_div2;

    // Two restoring steps. The remainder stays below the divisor, so it
    // fits in nine bits after each subtract.
    function automatic t_div2 div2(input logic [8:0] rem, input logic [1:0] nbits,
                                   input logic [8:0] dvs);
        logic [9:0] x;
        t_div2      res;
        x = {rem, nbits[1]};
        res.q[1] = (x >= {1'b0, dvs});
        if (res.q[1]) begin
            x = x - {1'b0, dvs};
        end
        x = {x[8:0], nbits[0]};
        res.q[0] = (x >= {1'b0, dvs});
        if (res.q[0]) begin
            x = x - {1'b0, dvs};
        end
        res.rem = x[8:0];
        return res;
    endfunction

endpackage

// ===== design/rgb_to_hsl_pixel_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB to HSL pixel core
// Converts an 8-bit RGBA pixel stream to fixed point hue, saturation and
// lightness sum, one pixel per clock unless the output stalls a full pipeline.
// ---------------------------------------------------------------------------
// Each pixel passes these stages from input beat to output beat: one stage finds
// max, min and the hue operand, one forms the two dividends, eight stages run
// the saturation and hue divisions side by side at two quotient bits each, and
// one stage adds the hue offset into the output register. A new pixel is taken
// every cycle unless a full pipeline meets a stall on the output side; empty
// stages close up during output stalls, so beats flow until the pipeline is full.
module rgb_to_hsl_pixel_core
    import rgbhsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // hue[14:0], saturation[30:15],
                                         // lightness_sum[39:31], alpha_out[47:40]
);

    // ---------------- stage A: max, min, hue operand ----------------
    logic [ChW-1:0]  w_r, w_g, w_b;
    logic [ChW-1:0]  w_mx, w_mn, w_d;
    logic [SumW-1:0] w_sum, w_den;
    logic [MulW-1:0] w_t;
    logic [HueW-1:0] w_offs;

    logic            r_a_vld;
    logic [ChW-1:0]  r_a_d;
    logic [SumW-1:0] r_a_sum, r_a_den;
    logic [MulW-1:0] r_a_t;
    logic [HueW-1:0] r_a_offs;
    logic [ChW-1:0]  r_a_alpha;

    logic            w_adv_a;
    logic            w_adv_out;
    logic [DivStages:0] w_adv;

    assign w_r = i_s_axis_tdata[7:0];
    assign w_g = i_s_axis_tdata[15:8];
    assign w_b = i_s_axis_tdata[23:16];

    always_comb begin
        w_mx  = (w_r > w_g) ? w_r : w_g;
        w_mx  = (w_mx > w_b) ? w_mx : w_b;
        w_mn  = (w_r < w_g) ? w_r : w_g;
        w_mn  = (w_mn < w_b) ? w_mn : w_b;
        w_sum = {1'b0, w_mx} + {1'b0, w_mn};
        w_d   = w_mx - w_mn;
        w_den = (w_sum <= 9'd255) ? w_sum : (9'd510 - w_sum);
        // Ties pick red first, then green.
        if (w_r == w_mx) begin
            w_offs = HueOffsRed;
            if (w_g < w_b) begin
                w_t = {1'b0, w_d, 2'b00} + {2'b00, w_d, 1'b0}
                      - {3'b000, w_b} + {3'b000, w_g};
            end else begin
                w_t = {3'b000, w_g} - {3'b000, w_b};
            end
        end else if (w_g == w_mx) begin
            w_offs = HueOffsGreen;
            w_t    = {3'b000, w_b} + {3'b000, w_d} - {3'b000, w_r};
        end else begin
            w_offs = HueOffsBlue;
            w_t    = {3'b000, w_r} + {3'b000, w_d} - {3'b000, w_g};
        end
    end

    assign o_s_axis_tready = w_adv_a;
    assign w_adv_a         = !r_a_vld || w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv_a) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_a_d     <= w_d;
            r_a_sum   <= w_sum;
            r_a_den   <= w_den;
            r_a_t     <= w_t;
            r_a_offs  <= w_offs;
            r_a_alpha <= i_s_axis_tdata[31:24];
        end
    end

    // ---------------- stage B: dividends ----------------
    logic [23:0] w_snum;
    logic [22:0] w_hnum;
    t_div_pl     n_pl0;

    t_div_pl            r_pl  [DivStages+1];
    logic [DivStages:0] r_vld;

    always_comb begin
        // 65535*d and 3840*t by shift and subtract.
        w_snum = {r_a_d, 16'h0000} - {16'h0000, r_a_d};
        w_hnum = {r_a_t, 12'h000} - {4'h0, r_a_t, 8'h00};
        n_pl0.srem  = {1'b0, w_snum[23:16]};
        n_pl0.snum  = w_snum[15:0];
        n_pl0.sden  = r_a_den;
        n_pl0.sq    = '0;
        n_pl0.hrem  = {1'b0, w_hnum[22:16]};
        n_pl0.hnum  = w_hnum[15:0];
        n_pl0.hdiv  = r_a_d;
        n_pl0.hq    = '0;
        n_pl0.hoffs = r_a_offs;
        n_pl0.gray  = (r_a_d == '0);
        n_pl0.sum   = r_a_sum;
        n_pl0.alpha = r_a_alpha;
    end

    assign w_adv[DivStages] = !r_vld[DivStages] || w_adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_pl[0] <= n_pl0;
        end
    end

    // ---------------- divider stages ----------------
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        t_div_pl n_pl;
        t_div2   w_sstep, w_hstep;

        assign w_adv[k] = !r_vld[k] || w_adv[k+1];

        always_comb begin
            w_sstep = div2(r_pl[k].srem, r_pl[k].snum[QuoW-1:QuoW-2], r_pl[k].sden);
            w_hstep = div2({1'b0, r_pl[k].hrem}, r_pl[k].hnum[QuoW-1:QuoW-2],
                           {1'b0, r_pl[k].hdiv});
            n_pl      = r_pl[k];
            n_pl.srem = w_sstep.rem;
            n_pl.snum = {r_pl[k].snum[QuoW-3:0], 2'b00};
            n_pl.sq   = {r_pl[k].sq[QuoW-3:0], w_sstep.q};
            n_pl.hrem = w_hstep.rem[7:0];
            n_pl.hnum = {r_pl[k].hnum[QuoW-3:0], 2'b00};
            n_pl.hq   = {r_pl[k].hq[QuoW-3:0], w_hstep.q};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_adv[k+1]) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k+1]) begin
                r_pl[k+1] <= n_pl;
            end
        end
    end

    // ---------------- output stage ----------------
    logic            r_o_vld;
    logic [HueW-1:0] r_o_hue;
    logic [SatW-1:0] r_o_sat;
    logic [SumW-1:0] r_o_sum;
    logic [ChW-1:0]  r_o_alpha;
    logic [HueW-1:0] n_o_hue;
    logic [SatW-1:0] n_o_sat;

    assign w_adv_out = !r_o_vld || i_m_axis_tready;

    always_comb begin
        if (r_pl[DivStages].gray) begin
            n_o_hue = '0;
            n_o_sat = '0;
        end else begin
            n_o_hue = r_pl[DivStages].hoffs + r_pl[DivStages].hq[HueW-1:0];
            n_o_sat = r_pl[DivStages].sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv_out) begin
            r_o_vld <= r_vld[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_o_hue   <= n_o_hue;
            r_o_sat   <= n_o_sat;
            r_o_sum   <= r_pl[DivStages].sum;
            r_o_alpha <= r_pl[DivStages].alpha;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_alpha, r_o_sum, r_o_sat, r_o_hue};

`ifndef NO_ASSERTIONS
    // An accepted input beat always lands in the first stage.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_a_vld)
        else $error("accepted pixel did not enter stage A");

    // A held pixel in the last divider stage is never dropped.
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DivStages] && !w_adv[DivStages] |=> r_vld[DivStages])
        else $error("stalled pixel lost in divider pipeline");

    // Zero saturation only comes from a gray pixel, which also has zero hue.
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && (r_o_sat == '0) |-> (r_o_hue == '0))
        else $error("zero saturation with nonzero hue");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_hue <= 15'd23039))
        else $error("hue out of range");
`endif

endmodule
